FILE: design/assert_macros.svh
// Assertion macros shared by the record sorter RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("expected follow-up missing");
`else
`define ASSERT_NEVER(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/rsbsk_pkg.sv
// Types and constants for the record sorter.
// No dependencies; used by the interfaces, controller, datapath and top level.
package rsbsk_pkg;

   localparam int KEY_W           = 8;
   localparam int GRADE_W         = 10;
   localparam int INDEX_W         = 5;
   localparam int MAX_RECORDS_DEF = 32;
   localparam int MAX_NAME_DEF    = 49;

   // one step of work for the datapath
   typedef enum logic [3:0] {
      OP_LOAD,
      OP_INIT,
      OP_HEAD,
      OP_CARRY,
      OP_CARRY_LEN,
      OP_NEXT,
      OP_NEXT_LEN,
      OP_CMP_RD,
      OP_CMP_CHK,
      OP_DECIDE,
      OP_PASS_END,
      OP_OUT_RD,
      OP_OUT_GRADE,
      OP_OUT_SHOW
   } rsbsk_op_type;

   typedef struct packed {
      rsbsk_op_type op;
   } rsbsk_cmd_type;

   typedef struct packed {
      logic list_end;   // final word of the list taken
      logic init_last;  // order table fill at its last entry
      logic single;     // only one record held
      logic cmp_end;    // shorter name exhausted
      logic byte_diff;  // compared bytes differ
      logic pass_done;  // last compare of this pass
      logic last_pass;  // pass just closed was the final one
      logic rsp_taken;  // result word accepted
      logic out_last;   // result at the final sorted place
   } rsbsk_status_type;

endpackage

FILE: design/rsbsk_if.sv
// Request and response channel interfaces of the record sorter.
// Depends on rsbsk_pkg for field widths.
interface rsbsk_req_if;
   import rsbsk_pkg::*;
   logic               valid;
   logic               ready;
   logic [KEY_W-1:0]   key_byte;
   logic [GRADE_W-1:0] grade;
   logic               end_of_name;
   logic               end_of_list;
   modport source (output valid, key_byte, grade, end_of_name, end_of_list, input ready);
   modport sink   (input valid, key_byte, grade, end_of_name, end_of_list, output ready);
endinterface

interface rsbsk_rsp_if;
   import rsbsk_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] record_index;
   logic [GRADE_W-1:0] grade_out;
   logic               overflow;
   logic               last;
   modport source (output valid, record_index, grade_out, overflow, last, input ready);
   modport sink   (input valid, record_index, grade_out, overflow, last, output ready);
endinterface

FILE: design/record_sort_by_string_key.sv
// Record sorter by name key.
// req_chan carries one name byte per word; end_of_name closes a record and
// its grade is taken on that word. end_of_list closes the final record (it
// counts as end of name too) and starts the sort. Loading takes one word per
// cycle. Names are kept up to MAX_NAME bytes; records past MAX_RECORDS are
// dropped and reported through overflow on every result of that list.
// Sorting is a stable bubble sort over an order table: with n records it
// first fills the table with one entry per record, then runs n-1 passes;
// each compare reads the two names a byte pair at a time through the single
// read port pair of the name memory. rsp_chan then gives one word per record
// in sorted order; last marks the final word. A stalled receiver holds the
// result word and the sorter in place. req_chan is not ready from the end of
// the list until the final result word is taken, after which the block is
// empty again. Reset empties the block; the stores need no clearing pass.
`include "assert_macros.svh"
module record_sort_by_string_key #(
   parameter int MAX_RECORDS = rsbsk_pkg::MAX_RECORDS_DEF,
   parameter int MAX_NAME    = rsbsk_pkg::MAX_NAME_DEF
) (
   input  logic         clock,
   input  logic         reset,
   rsbsk_req_if.sink    req_chan,
   rsbsk_rsp_if.source  rsp_chan
);
   import rsbsk_pkg::*;

   rsbsk_cmd_type    cmd;
   rsbsk_status_type st;

   rsbsk_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   rsbsk_dp #(
      .MAX_RECORDS (MAX_RECORDS),
      .MAX_NAME    (MAX_NAME)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .cmd   (cmd),
      .st    (st)
   );

   `ASSERT_NEVER(a_load_or_emit, clock, reset, req_chan.ready && rsp_chan.valid)
   `ASSERT_NEXT(a_list_stops_load, clock, reset, req_chan.valid && req_chan.ready && req_chan.end_of_list, !req_chan.ready)
   `ASSERT_NEXT(a_last_reopens, clock, reset, rsp_chan.valid && rsp_chan.ready && rsp_chan.last, req_chan.ready)

endmodule

FILE: design/rsbsk_ctrl.sv
// Sequencer of the record sorter: load, bubble passes, result emission.
// Depends on rsbsk_pkg; drives rsbsk_dp through command and status structs.
module rsbsk_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  rsbsk_pkg::rsbsk_status_type st,
   output rsbsk_pkg::rsbsk_cmd_type    cmd
);
   import rsbsk_pkg::*;

   typedef enum logic [13:0] {
      ST_LOAD      = 14'b00000000000001,
      ST_INIT      = 14'b00000000000010,
      ST_HEAD      = 14'b00000000000100,
      ST_CARRY     = 14'b00000000001000,
      ST_CARRY_LEN = 14'b00000000010000,
      ST_NEXT      = 14'b00000000100000,
      ST_NEXT_LEN  = 14'b00000001000000,
      ST_CMP_RD    = 14'b00000010000000,
      ST_CMP_CHK   = 14'b00000100000000,
      ST_DECIDE    = 14'b00001000000000,
      ST_PASS_END  = 14'b00010000000000,
      ST_OUT_RD    = 14'b00100000000000,
      ST_OUT_GRADE = 14'b01000000000000,
      ST_OUT_SHOW  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_LOAD;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.op = OP_LOAD;
            if (st.list_end) state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.op = OP_INIT;
            if (st.init_last) state_in = st.single ? ST_OUT_RD : ST_HEAD;
         end
         ST_HEAD: begin
            cmd.op   = OP_HEAD;
            state_in = ST_CARRY;
         end
         ST_CARRY: begin
            cmd.op   = OP_CARRY;
            state_in = ST_CARRY_LEN;
         end
         ST_CARRY_LEN: begin
            cmd.op   = OP_CARRY_LEN;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            cmd.op   = OP_NEXT;
            state_in = ST_NEXT_LEN;
         end
         ST_NEXT_LEN: begin
            cmd.op   = OP_NEXT_LEN;
            state_in = ST_CMP_RD;
         end
         ST_CMP_RD: begin
            cmd.op   = OP_CMP_RD;
            state_in = st.cmp_end ? ST_DECIDE : ST_CMP_CHK;
         end
         ST_CMP_CHK: begin
            cmd.op   = OP_CMP_CHK;
            state_in = st.byte_diff ? ST_DECIDE : ST_CMP_RD;
         end
         ST_DECIDE: begin
            cmd.op   = OP_DECIDE;
            state_in = st.pass_done ? ST_PASS_END : ST_NEXT;
         end
         ST_PASS_END: begin
            cmd.op   = OP_PASS_END;
            state_in = st.last_pass ? ST_OUT_RD : ST_HEAD;
         end
         ST_OUT_RD: begin
            cmd.op   = OP_OUT_RD;
            state_in = ST_OUT_GRADE;
         end
         ST_OUT_GRADE: begin
            cmd.op   = OP_OUT_GRADE;
            state_in = ST_OUT_SHOW;
         end
         ST_OUT_SHOW: begin
            cmd.op = OP_OUT_SHOW;
            if (st.rsp_taken) state_in = st.out_last ? ST_LOAD : ST_OUT_RD;
         end
         default: begin
            cmd.op   = OP_LOAD;
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

FILE: design/rsbsk_dp.sv
// Datapath of the record sorter: name, length, grade and order memories,
// compare logic and list counters. Depends on rsbsk_pkg and rsbsk_if.
module rsbsk_dp #(
   parameter int MAX_RECORDS = rsbsk_pkg::MAX_RECORDS_DEF,
   parameter int MAX_NAME    = rsbsk_pkg::MAX_NAME_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   rsbsk_req_if.sink                   req,
   rsbsk_rsp_if.source                 rsp,
   input  rsbsk_pkg::rsbsk_cmd_type    cmd,
   output rsbsk_pkg::rsbsk_status_type st
);
   import rsbsk_pkg::*;

   localparam int IDX_W      = $clog2(MAX_RECORDS);
   localparam int CNT_W      = $clog2(MAX_RECORDS + 1);
   localparam int LEN_W      = $clog2(MAX_NAME + 1);
   localparam int ADDR_W     = IDX_W + LEN_W;
   localparam int NAME_DEPTH = MAX_RECORDS * (2 ** LEN_W);

   // each record owns a power-of-two slot of name bytes
   logic [KEY_W-1:0]   name_mem  [NAME_DEPTH];
   logic [LEN_W-1:0]   len_mem   [MAX_RECORDS];
   logic [GRADE_W-1:0] grade_mem [MAX_RECORDS];
   logic [IDX_W-1:0]   order_mem [MAX_RECORDS];

   logic [KEY_W-1:0]   name_a_ff, name_b_ff;
   logic [LEN_W-1:0]   len_rd_ff;
   logic [GRADE_W-1:0] grade_rd_ff;
   logic [IDX_W-1:0]   order_rd_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic               dropped_ff, dropped_in;

   logic [IDX_W-1:0]   ptr_ff, pass_len_ff, carry_idx_ff, next_idx_ff, out_idx_ff;
   logic [LEN_W-1:0]   carry_len_ff, next_len_ff, k_ff;
   logic               after_ff;

   logic               accept, eon, room, pos_room, list_clear;
   logic [LEN_W-1:0]   pos_inc, min_len;
   logic [CNT_W-1:0]   cnt_m1;
   logic [IDX_W-1:0]   last_idx, rec_slot;
   logic               name_we, rec_we;

   logic               order_re, order_we;
   logic [IDX_W-1:0]   order_raddr, order_waddr, order_wdata;

   // ---------------- load side ----------------
   assign req.ready  = (cmd.op == OP_LOAD);
   assign accept     = req.valid && req.ready;
   assign eon        = req.end_of_name || req.end_of_list;
   assign room       = (count_ff < CNT_W'(MAX_RECORDS));
   assign pos_room   = (pos_ff < LEN_W'(MAX_NAME));
   assign pos_inc    = pos_room ? pos_ff + LEN_W'(1) : pos_ff;
   assign rec_slot   = count_ff[IDX_W-1:0];
   assign name_we    = accept && room && pos_room;
   assign rec_we     = accept && room && eon;
   assign cnt_m1     = count_ff - CNT_W'(1);
   assign last_idx   = cnt_m1[IDX_W-1:0];
   assign list_clear = (cmd.op == OP_OUT_SHOW) && rsp.valid && rsp.ready &&
                       (ptr_ff == last_idx);

   always_comb begin
      count_in   = count_ff;
      pos_in     = pos_ff;
      dropped_in = dropped_ff;
      if (list_clear) begin
         count_in   = '0;
         pos_in     = '0;
         dropped_in = 1'b0;
      end else if (accept) begin
         if (room) begin
            pos_in = eon ? '0 : pos_inc;
            if (eon) count_in = count_ff + CNT_W'(1);
         end else if (eon) begin
            pos_in     = '0;
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pos_ff     <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         pos_ff     <= pos_in;
         dropped_ff <= dropped_in;
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (name_we) name_mem[{rec_slot, pos_ff}] <= req.key_byte;
      if (cmd.op == OP_CMP_RD) begin
         name_a_ff <= name_mem[ADDR_W'({carry_idx_ff, k_ff})];
         name_b_ff <= name_mem[ADDR_W'({next_idx_ff, k_ff})];
      end
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         len_mem[rec_slot]   <= pos_inc;
         grade_mem[rec_slot] <= req.grade;
      end
      if (cmd.op == OP_CARRY || cmd.op == OP_NEXT) len_rd_ff <= len_mem[order_rd_ff];
      if (cmd.op == OP_OUT_GRADE) grade_rd_ff <= grade_mem[order_rd_ff];
   end

   always_comb begin
      order_re    = 1'b0;
      order_raddr = ptr_ff;
      order_we    = 1'b0;
      order_waddr = ptr_ff;
      order_wdata = ptr_ff;
      unique case (cmd.op)
         OP_INIT: order_we = 1'b1;
         OP_HEAD: begin
            order_re    = 1'b1;
            order_raddr = '0;
         end
         OP_CARRY_LEN: begin
            order_re    = 1'b1;
            order_raddr = ptr_ff + IDX_W'(1);
         end
         OP_DECIDE: begin
            // the larger of the pair moves on; the other settles here
            order_re    = 1'b1;
            order_raddr = ptr_ff + IDX_W'(2);
            order_we    = 1'b1;
            order_wdata = after_ff ? next_idx_ff : carry_idx_ff;
         end
         OP_PASS_END: begin
            order_we    = 1'b1;
            order_waddr = pass_len_ff;
            order_wdata = carry_idx_ff;
         end
         OP_OUT_RD: order_re = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (order_we) order_mem[order_waddr] <= order_wdata;
      if (order_re) order_rd_ff <= order_mem[order_raddr];
   end

   // ---------------- sort sequencing ----------------
   assign min_len = (carry_len_ff < next_len_ff) ? carry_len_ff : next_len_ff;

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         // order table fill starts at entry 0
         OP_LOAD:      ptr_ff <= '0;
         OP_INIT: begin
            pass_len_ff <= last_idx;
            ptr_ff      <= (ptr_ff == last_idx) ? '0 : ptr_ff + IDX_W'(1);
         end
         OP_HEAD:      ptr_ff <= '0;
         OP_CARRY:     carry_idx_ff <= order_rd_ff;
         OP_CARRY_LEN: carry_len_ff <= len_rd_ff;
         OP_NEXT: begin
            next_idx_ff <= order_rd_ff;
            k_ff        <= '0;
         end
         OP_NEXT_LEN:  next_len_ff <= len_rd_ff;
         OP_CMP_RD: begin
            if (k_ff == min_len) after_ff <= (carry_len_ff > next_len_ff);
         end
         OP_CMP_CHK: begin
            after_ff <= (name_a_ff > name_b_ff);
            k_ff     <= k_ff + LEN_W'(1);
         end
         OP_DECIDE: begin
            if (!after_ff) begin
               carry_idx_ff <= next_idx_ff;
               carry_len_ff <= next_len_ff;
            end
            ptr_ff <= ptr_ff + IDX_W'(1);
         end
         OP_PASS_END: begin
            pass_len_ff <= pass_len_ff - IDX_W'(1);
            ptr_ff      <= '0;
         end
         OP_OUT_GRADE: out_idx_ff <= order_rd_ff;
         OP_OUT_SHOW: begin
            if (rsp.ready) ptr_ff <= ptr_ff + IDX_W'(1);
         end
         default: ;
      endcase
   end

   // ---------------- result word ----------------
   assign rsp.valid        = (cmd.op == OP_OUT_SHOW);
   assign rsp.record_index = INDEX_W'(out_idx_ff);
   assign rsp.grade_out    = grade_rd_ff;
   assign rsp.overflow     = dropped_ff;
   assign rsp.last         = (ptr_ff == last_idx);

   // ---------------- status ----------------
   assign st.list_end  = accept && req.end_of_list;
   assign st.init_last = (ptr_ff == last_idx);
   assign st.single    = (count_ff == CNT_W'(1));
   assign st.cmp_end   = (k_ff == min_len);
   assign st.byte_diff = (name_a_ff != name_b_ff);
   assign st.pass_done = (ptr_ff == pass_len_ff - IDX_W'(1));
   assign st.last_pass = (pass_len_ff == IDX_W'(1));
   assign st.rsp_taken = rsp.valid && rsp.ready;
   assign st.out_last  = (ptr_ff == last_idx);

endmodule
